[rtl/gmnv_pkg.sv]
// Package with shared types and constants for the greedy nearest-vertex unit.
`timescale 1ns / 1ps
package gmnv_pkg;
	localparam int unsigned MaxVerticesDef = 4096;
	localparam int unsigned MaxDegreeDef   = 32;
	localparam int unsigned CoordBitsDef   = 24;
	localparam int unsigned DistBits       = 50;
	localparam int unsigned VidBits        = 12;
	localparam int unsigned SlotBits       = 5;
	localparam int unsigned DegBits        = 6;
	localparam int unsigned HopBits        = 13;
	localparam int unsigned CmpBits        = 18;
	localparam int unsigned InBits         = 2 + VidBits + SlotBits + VidBits + DegBits + 3 * 24;
	localparam int unsigned InBytesBits    = ((InBits + 7) / 8) * 8;
	localparam int unsigned OutBits        = VidBits + DistBits + HopBits + CmpBits;
	localparam int unsigned OutBytesBits   = ((OutBits + 7) / 8) * 8;

	typedef enum logic [1:0] {
		REQ_POINT    = 2'd0,
		REQ_NEIGHBOR = 2'd1,
		REQ_DEGREE   = 2'd2,
		REQ_QUERY    = 2'd3
	} req_t;

	// One decoded item as it waits in the queue between front and back.
	typedef struct packed {
		req_t                 req;
		logic [VidBits-1:0]   vertex;
		logic [SlotBits-1:0]  slot;
		logic [VidBits-1:0]   neighbor;
		logic [DegBits-1:0]   degree;
		logic [23:0]          cx;
		logic [23:0]          cy;
		logic [23:0]          cz;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START_RD,
		ST_START_DIST,
		ST_HOP,
		ST_DEG_WAIT,
		ST_NB_WAIT,
		ST_PT_WAIT,
		ST_SQUARE,
		ST_DIST,
		ST_CMP,
		ST_HOP_END,
		ST_OUT
	} state_t;
endpackage

[rtl/gmnv_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module gmnv_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/gmnv_front.sv]
// Front end: accepts input transfers, unpacks them and feeds a two-entry queue.
`timescale 1ns / 1ps
module gmnv_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [gmnv_pkg::InBytesBits-1:0] s_tdata,
	output logic                         q_valid,
	input  logic                         q_pop,
	output gmnv_pkg::item_t              q_item
);
	import gmnv_pkg::*;

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       push;

	// Field unpacking, first field in the lowest bits.
	always_comb begin
		in_item.req      = req_t'(s_tdata[1:0]);
		in_item.vertex   = s_tdata[13:2];
		in_item.slot     = s_tdata[18:14];
		in_item.neighbor = s_tdata[30:19];
		in_item.degree   = s_tdata[36:31];
		in_item.cx       = s_tdata[60:37];
		in_item.cy       = s_tdata[84:61];
		in_item.cz       = s_tdata[108:85];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

[rtl/gmnv_back.sv]
// Back end: store writes and the greedy descent sequencer.
`timescale 1ns / 1ps
module gmnv_back #(
	parameter int unsigned MAX_VERTICES = gmnv_pkg::MaxVerticesDef,
	parameter int unsigned MAX_DEGREE   = gmnv_pkg::MaxDegreeDef,
	parameter int unsigned COORD_BITS   = gmnv_pkg::CoordBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  gmnv_pkg::item_t               q_item,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gmnv_pkg::OutBytesBits-1:0] m_tdata
);
	import gmnv_pkg::*;

	localparam int unsigned VB  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned NBD = MAX_VERTICES * MAX_DEGREE;
	localparam int unsigned NB  = $clog2(NBD);
	localparam int unsigned DB  = $clog2(MAX_DEGREE + 1);
	localparam int unsigned CB  = COORD_BITS;
	localparam int unsigned PW  = 3 * CB;
	localparam int unsigned SQB = 2 * (CB + 1);
	localparam int unsigned SUMB = SQB + 2;
	localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

	state_t state_q, state_d;

	// Query registers.
	logic [CB-1:0]       qx_q, qy_q, qz_q;
	logic [VB-1:0]       cur_q, next_q, cand_q;
	logic [DistBits-1:0] best_q, best_before_q;
	logic [HopBits-1:0]  hops_q;
	logic [CmpBits-1:0]  cmp_q;
	logic [DB-1:0]       deg_q;
	logic [DB-1:0]       idx_q;
	logic [SQB-1:0]      sqx_s1, sqy_s1, sqz_s1;
	logic [DistBits-1:0] dist_q;
	logic                out_valid_q;
	logic [OutBits-1:0]  out_q;

	// Memory ports.
	logic          pt_we, nb_we, dg_we;
	logic [VB-1:0] pt_waddr, pt_raddr, dg_waddr, dg_raddr;
	logic [NB-1:0] nb_waddr, nb_raddr;
	logic [PW-1:0] pt_wdata, pt_rdata;
	logic [VB-1:0] nb_rdata;
	logic [DB-1:0] dg_wdata, dg_rdata;

	logic is_write;
	logic [VB-1:0] in_v, in_nb;
	logic [DegBits-1:0] in_deg;

	assign is_write = (q_item.req != REQ_QUERY);
	assign in_v     = VB'(q_item.vertex % MAX_VERTICES);
	assign in_nb    = VB'(q_item.neighbor % MAX_VERTICES);
	assign in_deg   = q_item.degree;

	// Writes are taken straight from the queue while the sequencer is idle.
	always_comb begin
		pt_we    = (state_q == ST_IDLE) && q_valid && (q_item.req == REQ_POINT);
		nb_we    = (state_q == ST_IDLE) && q_valid && (q_item.req == REQ_NEIGHBOR)
			&& ({27'd0, q_item.slot} < 32'(MAX_DEGREE));
		dg_we    = (state_q == ST_IDLE) && q_valid && (q_item.req == REQ_DEGREE);
		pt_waddr = in_v;
		dg_waddr = in_v;
		nb_waddr = NB'(32'(in_v) * MAX_DEGREE + 32'(q_item.slot));
		pt_wdata = {q_item.cz[CB-1:0], q_item.cy[CB-1:0], q_item.cx[CB-1:0]};
		if ({26'd0, in_deg} > 32'(MAX_DEGREE)) begin
			dg_wdata = DB'(MAX_DEGREE);
		end else begin
			dg_wdata = DB'(in_deg);
		end
	end

	// Read addresses. The point of a neighbour is addressed as soon as its id leaves the
	// neighbour memory, and the degree of the vertex about to be visited during the hop.
	always_comb begin
		pt_raddr = cand_q;
		if (state_q == ST_START_RD) begin
			pt_raddr = cur_q;
		end else if (state_q == ST_PT_WAIT) begin
			pt_raddr = nb_rdata;
		end
		dg_raddr = next_q;
		nb_raddr = NB'(32'(cur_q) * MAX_DEGREE + 32'(idx_q));
	end

	gmnv_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pt (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);
	gmnv_ram #(.WIDTH(VB), .DEPTH(NBD)) u_nb (
		.clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(in_nb),
		.raddr(nb_raddr), .rdata(nb_rdata)
	);
	gmnv_ram #(.WIDTH(DB), .DEPTH(MAX_VERTICES)) u_dg (
		.clk(clk), .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
		.raddr(dg_raddr), .rdata(dg_rdata)
	);

	// Coordinate differences, squared one per axis into stage registers.
	logic signed [CB:0] dx, dy, dz;
	logic [CB:0]        ax, ay, az;
	logic [SUMB-1:0]    sum;
	always_comb begin
		dx = $signed({qx_q[CB-1], qx_q}) - $signed({pt_rdata[CB-1], pt_rdata[CB-1:0]});
		dy = $signed({qy_q[CB-1], qy_q})
			- $signed({pt_rdata[2*CB-1], pt_rdata[2*CB-1:CB]});
		dz = $signed({qz_q[CB-1], qz_q})
			- $signed({pt_rdata[3*CB-1], pt_rdata[3*CB-1:2*CB]});
		ax = dx[CB] ? (CB+1)'(-dx) : dx;
		ay = dy[CB] ? (CB+1)'(-dy) : dy;
		az = dz[CB] ? (CB+1)'(-dz) : dz;
		sum = SUMB'(sqx_s1) + SUMB'(sqy_s1) + SUMB'(sqz_s1);
	end

	logic [DistBits-1:0] sum_sat;
	always_comb begin
		if (SUMB > DistBits && (sum >> DistBits) != '0) begin
			sum_sat = DistMax;
		end else begin
			sum_sat = DistBits'(sum);
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (q_valid && !is_write && !out_valid_q) state_d = ST_START_RD;
			ST_START_RD:   state_d = ST_START_DIST;
			ST_START_DIST: state_d = ST_DIST;
			ST_HOP:        state_d = ST_DEG_WAIT;
			ST_DEG_WAIT:   state_d = (dg_rdata == '0) ? ST_HOP_END : ST_NB_WAIT;
			ST_NB_WAIT:    state_d = ST_PT_WAIT;
			ST_PT_WAIT:    state_d = ST_SQUARE;
			ST_SQUARE:     state_d = ST_DIST;
			ST_DIST:       state_d = ST_CMP;
			ST_CMP: begin
				if (hops_q == '0) begin
					state_d = ST_HOP;
				end else if (idx_q == deg_q) begin
					state_d = ST_HOP_END;
				end else begin
					state_d = ST_NB_WAIT;
				end
			end
			ST_HOP_END: begin
				if (best_q < best_before_q && 32'(hops_q) < MAX_VERTICES) begin
					state_d = ST_HOP;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT:        state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Output-side decode.
	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_valid && (is_write || !out_valid_q);
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		sqx_s1 <= SQB'(ax * ax);
		sqy_s1 <= SQB'(ay * ay);
		sqz_s1 <= SQB'(az * az);
		case (state_q)
			ST_IDLE: begin
				qx_q   <= q_item.cx[CB-1:0];
				qy_q   <= q_item.cy[CB-1:0];
				qz_q   <= q_item.cz[CB-1:0];
				cur_q  <= in_v;
				next_q <= in_v;
				hops_q <= '0;
				cmp_q  <= '0;
			end
			ST_HOP: begin
				cur_q         <= next_q;
				hops_q        <= hops_q + 1'b1;
				best_before_q <= best_q;
				idx_q         <= '0;
			end
			ST_DEG_WAIT: begin
				deg_q <= dg_rdata;
			end
			ST_NB_WAIT: begin
				idx_q <= idx_q + 1'b1;
			end
			ST_PT_WAIT: begin
				cand_q <= nb_rdata;
			end
			ST_DIST: begin
				dist_q <= sum_sat;
			end
			ST_CMP: begin
				if (hops_q == '0) begin
					best_q <= dist_q;
				end else begin
					cmp_q <= cmp_q + 1'b1;
					if (dist_q < best_q) begin
						best_q <= dist_q;
						next_q <= cand_q;
					end
				end
			end
			ST_OUT: begin
				out_q <= {cmp_q, hops_q, best_q, VidBits'(next_q)};
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OutBytesBits'(out_q);
endmodule

[rtl/greedy_mesh_nearest_vertex_unit.sv]
// Top level of the greedy nearest-vertex unit: input queue front end and descent back end.
// An accepted transfer is registered in the queue before the back end sees it; writes retire back to back while idle.
// After a query leaves the queue, each visited vertex takes a degree read and then,
// for each of its neighbours in turn, serial neighbour and point reads.
// One query runs at a time; a result waiting for m_tready holds back the next query.
// Reset (arst_n, asynchronous, active low) empties the queue and idles the sequencer;
// memory contents are undefined until written.
`timescale 1ns / 1ps
module greedy_mesh_nearest_vertex_unit #(
	parameter int unsigned MAX_VERTICES = gmnv_pkg::MaxVerticesDef,
	parameter int unsigned MAX_DEGREE   = gmnv_pkg::MaxDegreeDef,
	parameter int unsigned COORD_BITS   = gmnv_pkg::CoordBitsDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// req_type[1:0], vertex[13:2], slot[18:14], neighbor[30:19], degree[36:31],
	// coord_x[60:37], coord_y[84:61], coord_z[108:85], zero fill above.
	input  logic [gmnv_pkg::InBytesBits-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// nearest_vertex[11:0], best_distance_sq[61:12], hops[74:62],
	// compares[92:75], zero fill above.
	output logic [gmnv_pkg::OutBytesBits-1:0] m_tdata
);
	import gmnv_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;

	gmnv_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	gmnv_back #(
		.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE), .COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);
endmodule
